[design/tre_pkg.sv]
// Shared types, constants and helpers for the text respacer.
package tre_pkg;

  localparam int COLUMN_LIMIT = 255;
  localparam logic [8:0] COL_LIMIT9 = 9'(COLUMN_LIMIT);

  localparam int LREP_W   = 4;
  localparam int INDENT_W = 7;
  localparam logic [LREP_W-1:0]   LREP_RESET   = 4'd2;
  localparam logic [INDENT_W-1:0] INDENT_RESET = 7'd0;

  // Character codes
  localparam logic [7:0] CH_HT  = 8'h09;
  localparam logic [7:0] CH_NL  = 8'h0A;
  localparam logic [7:0] CH_FF  = 8'h0C;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_RS  = 8'h1E;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_META   = 8'h80;
  localparam logic [7:0] CH_METASP = 8'hA0;

  // Datapath operations
  localparam logic [1:0] OP_IDLE  = 2'd0;
  localparam logic [1:0] OP_NL    = 2'd1;
  localparam logic [1:0] OP_CR    = 2'd2;
  localparam logic [1:0] OP_PRINT = 2'd3;

  // Byte classes of an incoming word
  localparam logic [1:0] CLS_BLANK = 2'd0;
  localparam logic [1:0] CLS_NL    = 2'd1;
  localparam logic [1:0] CLS_CR    = 2'd2;
  localparam logic [1:0] CLS_PRINT = 2'd3;

  // Register indexes
  localparam logic REG_LREP   = 1'b0;
  localparam logic REG_INDENT = 1'b1;

  typedef struct packed {
    logic       accept;
    logic [1:0] op;
  } tre_cmd_t;

  typedef struct packed {
    logic [1:0] cls;
    logic       done;
  } tre_stat_t;

  function automatic logic [7:0] sat_col(input logic [8:0] v);
    return (v > COL_LIMIT9) ? COL_LIMIT9[7:0] : v[7:0];
  endfunction

endpackage

[design/tre_ctrl.sv]
// Sequencer for the text respacer: picks the datapath operation per word.
module tre_ctrl
  import tre_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  tre_stat_t stat,
  output tre_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_NL    = 2'd1;
  localparam logic [1:0] S_CR    = 2'd2;
  localparam logic [1:0] S_PRINT = 2'd3;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd.accept = 1'b0;
    cmd.op     = OP_IDLE;
    unique case (state_r)
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) begin
          unique case (stat.cls)
            CLS_NL:    state_nxt = S_NL;
            CLS_CR:    state_nxt = S_CR;
            CLS_PRINT: state_nxt = S_PRINT;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_NL: begin
        cmd.op = OP_NL;
        if (stat.done) state_nxt = S_IDLE;
      end
      S_CR: begin
        cmd.op = OP_CR;
        if (stat.done) state_nxt = S_IDLE;
      end
      S_PRINT: begin
        cmd.op = OP_PRINT;
        if (stat.done) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Blanks only move the column: the sequencer stays idle after them
  a_blank_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid && stat.cls == CLS_BLANK) |=> state_r == S_IDLE)
    else $error("blank word left idle state");

  // A finished operation always returns to idle
  a_done_returns: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE && stat.done) |=> state_r == S_IDLE)
    else $error("operation done but not idle");

endmodule

[design/tre_dp.sv]
// Datapath for the text respacer: columns, gap emission and output register.
module tre_dp
  import tre_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  tre_cmd_t            cmd,
  output tre_stat_t           stat,
  input  logic [LREP_W-1:0]   line_repeat,
  input  logic [INDENT_W-1:0] indent_columns,
  input  logic [7:0]          in_data_byte,
  input  logic                in_new_file,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                out_last
);

  logic [7:0]        ic_r, ic_nxt, oc_r, oc_nxt;
  logic [7:0]        byte_r, byte_nxt;
  logic [LREP_W-1:0] cnt_r, cnt_nxt;
  logic              ov_r, ov_nxt, ol_r, ol_nxt;
  logic [7:0]        ob_r, ob_nxt;

  logic       out_free;
  logic [7:0] ic_base, oc_base, target, gap_oc;
  logic [8:0] stop;
  logic       gap, use_tab, is_bs, drop, is_ctl;

  assign out_free = !ov_r || out_ready;
  assign ic_base  = in_new_file ? 8'd0 : ic_r;
  assign oc_base  = in_new_file ? 8'd0 : oc_r;

  assign target  = sat_col({1'b0, ic_r} + {2'b00, indent_columns});
  assign gap     = target > oc_r;
  assign stop    = ({1'b0, oc_r} + 9'd8) & ~9'd7;
  assign use_tab = stop <= {1'b0, target};
  assign gap_oc  = use_tab ? stop[7:0] : oc_r + 8'd1;

  assign is_bs  = (byte_r == CH_BS) || (byte_r == CH_RS);
  assign drop   = is_bs && (ic_r == 8'd0);
  assign is_ctl = ((byte_r != 8'd0) && (byte_r < CH_SP)) ||
                  ((byte_r > CH_META) && (byte_r < CH_METASP));

  always_comb begin
    ic_nxt    = ic_r;
    oc_nxt    = oc_r;
    cnt_nxt   = cnt_r;
    byte_nxt  = byte_r;
    ov_nxt    = ov_r && !out_ready;
    ob_nxt    = ob_r;
    ol_nxt    = ol_r;
    stat.done = 1'b0;

    if (in_data_byte == CH_SP || in_data_byte == CH_HT) stat.cls = CLS_BLANK;
    else if (in_data_byte == CH_NL)                    stat.cls = CLS_NL;
    else if (in_data_byte == CH_CR || in_data_byte == CH_FF) stat.cls = CLS_CR;
    else                                                stat.cls = CLS_PRINT;

    if (cmd.accept) begin
      byte_nxt = in_data_byte;
      cnt_nxt  = line_repeat;
      ic_nxt   = ic_base;
      oc_nxt   = oc_base;
      if (in_data_byte == CH_SP) begin
        ic_nxt = sat_col({1'b0, ic_base} + 9'd1);
      end else if (in_data_byte == CH_HT) begin
        ic_nxt = sat_col({1'b0, ic_base & ~8'h07} + 9'd8);
      end
    end

    case (cmd.op)
      OP_NL: begin
        if (cnt_r == '0) begin
          ic_nxt    = 8'd0;
          oc_nxt    = 8'd0;
          stat.done = 1'b1;
        end else if (out_free) begin
          ov_nxt  = 1'b1;
          ob_nxt  = CH_NL;
          ol_nxt  = (cnt_r == LREP_W'(1));
          cnt_nxt = cnt_r - LREP_W'(1);
          if (cnt_r == LREP_W'(1)) begin
            ic_nxt    = 8'd0;
            oc_nxt    = 8'd0;
            stat.done = 1'b1;
          end
        end
      end
      OP_CR: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          ob_nxt    = byte_r;
          ol_nxt    = 1'b1;
          ic_nxt    = 8'd0;
          oc_nxt    = 8'd0;
          stat.done = 1'b1;
        end
      end
      OP_PRINT: begin
        if (gap) begin
          if (out_free) begin
            ov_nxt = 1'b1;
            ob_nxt = use_tab ? CH_HT : CH_SP;
            ol_nxt = (gap_oc == target) && drop;
            oc_nxt = gap_oc;
          end
        end else if (drop) begin
          stat.done = 1'b1;
        end else if (out_free) begin
          ov_nxt    = 1'b1;
          ob_nxt    = byte_r;
          ol_nxt    = 1'b1;
          stat.done = 1'b1;
          if (is_bs) begin
            ic_nxt = ic_r - 8'd1;
            if (oc_r != 8'd0) oc_nxt = oc_r - 8'd1;
          end else if (!is_ctl) begin
            ic_nxt = sat_col({1'b0, ic_r} + 9'd1);
            oc_nxt = sat_col({1'b0, oc_r} + 9'd1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ic_r <= 8'd0;
      oc_r <= 8'd0;
      ov_r <= 1'b0;
    end else begin
      ic_r <= ic_nxt;
      oc_r <= oc_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    cnt_r  <= cnt_nxt;
    ob_r   <= ob_nxt;
    ol_r   <= ol_nxt;
  end

  assign out_valid = ov_r;
  assign out_byte  = ob_r;
  assign out_last  = ol_r;

  a_ic_limit: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, ic_r} <= COL_LIMIT9)
    else $error("input column above limit");

  a_oc_limit: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, oc_r} <= COL_LIMIT9)
    else $error("output column above limit");

  // An empty newline run still clears both columns
  a_nl_zero_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_NL && cnt_r == '0) |=> (ic_r == 8'd0 && oc_r == 8'd0))
    else $error("empty newline run kept columns");

endmodule

[design/text_respacer_entab.sv]
// Top level of the text respacer: register port, sequencer and datapath.
//
// Input channel (in_valid/in_ready, in_data_byte, in_new_file) takes one text
// byte per word. Output channel (out_valid/out_ready, out_byte, out_last)
// gives the bytes that word causes; out_last marks the final one. A word that
// causes nothing (space, tab, dropped backspace with no gap, newline with
// line_repeat 0) produces no output word.
// Every word but a space or tab takes the sequencer out of idle, which holds
// in_ready low until the word is done. The datapath emits its bytes (up to 38
// gap bytes plus the byte itself, or line_repeat newlines) one byte per cycle
// while the output register is free; an empty newline or a dropped backspace
// with no gap still passes through a busy state. out_valid comes from the
// output register, loaded after the sequencer state register takes the word.
// The output register lets the next word be accepted while the last result
// still waits; when the receiver stalls, emission holds and in_ready drops
// once the current word is under way.
// Reset (rst_n low, synchronous) clears both columns, the output register,
// line_repeat to 2 and indent_columns to 0.
// Registers: 0x0 line_repeat[3:0], 0x4 indent_columns[6:0].
module text_respacer_entab
  import tre_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_new_file,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last
);

  logic [LREP_W-1:0]   lrep_r, lrep_nxt;
  logic [INDENT_W-1:0] indent_r, indent_nxt;
  logic                wr_en;
  tre_cmd_t            cmd;
  tre_stat_t           stat;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Decode the word index from address bit 2
  always_comb begin
    lrep_nxt   = lrep_r;
    indent_nxt = indent_r;
    if (wr_en) begin
      unique case (paddr[2])
        REG_LREP:   lrep_nxt   = pwdata[LREP_W-1:0];
        REG_INDENT: indent_nxt = pwdata[INDENT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_LREP:   prdata = {{(32-LREP_W){1'b0}}, lrep_r};
      REG_INDENT: prdata = {{(32-INDENT_W){1'b0}}, indent_r};
      default:    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lrep_r   <= LREP_RESET;
      indent_r <= INDENT_RESET;
    end else begin
      lrep_r   <= lrep_nxt;
      indent_r <= indent_nxt;
    end
  end

  // Advance one word at a time; the sequencer owns in_ready
  tre_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .cmd      (cmd)
  );

  assign in_ready = (cmd.op == OP_IDLE);

  tre_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .line_repeat    (lrep_r),
    .indent_columns (indent_r),
    .in_data_byte   (in_data_byte),
    .in_new_file    (in_new_file),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_last       (out_last)
  );

endmodule

[sim/tb_text_respacer_entab.sv]
// Self-checking testbench for the text respacer: directed table, then random text.
`timescale 1ns / 1ps

module tb_text_respacer_entab;
  import tre_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;  // cycles without any handshake
  localparam int HOLD_CYCLES    = 150;   // long receiver hold-off
  localparam int SETTLE_CYCLES  = 6;     // lets empty words finish
  localparam int WORDS_PER_SET  = 21;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } out_word_t;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_e;

  // One directed row: either a word to send or a register write. Rows marked
  // typed carry their result by hand: exp_cnt copies of exp_ch.
  typedef struct packed {
    row_kind_e           kind;
    logic [7:0]          ch;
    logic                nf;
    logic                typed;
    logic [7:0]          exp_ch;
    logic [4:0]          exp_cnt;
    logic                reg_sel;
    logic [INDENT_W-1:0] reg_val;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = '0;
  logic        in_new_file = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        out_last;

  // Shadow copy of the block: registers and both columns.
  logic [LREP_W-1:0]   shadow_lrep   = LREP_RESET;
  logic [INDENT_W-1:0] shadow_indent = INDENT_RESET;
  logic [7:0]          col_in  = '0;
  logic [7:0]          col_out = '0;

  out_word_t expected_bytes[$];
  out_word_t predicted_bytes[$];
  stim_row_t directed_rows[$];

  int error_count   = 0;
  int tx_idle_pct   = 0;
  int rx_idle_pct   = 0;
  int hold_requests = 0;
  int holds_seen    = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;
  int tab_run       = 0;

  text_respacer_entab DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data_byte(in_data_byte),
    .in_new_file (in_new_file),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .out_last    (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] clamp_col(input int v);
    return (v > COLUMN_LIMIT) ? 8'(COLUMN_LIMIT) : 8'(v);
  endfunction

  function automatic void put_byte(input logic [7:0] c);
    predicted_bytes.push_back('{ch: c, last: 1'b0});
  endfunction

  // Work out the bytes one input word causes and advance the shadow columns.
  function automatic void respace_word(input logic [7:0] c, input logic nf);
    int tgt;
    predicted_bytes.delete();
    if (nf) begin
      col_in  = '0;
      col_out = '0;
    end
    if (c == CH_NL) begin
      repeat (shadow_lrep) put_byte(CH_NL);
      col_in  = '0;
      col_out = '0;
    end else if (c == CH_CR || c == CH_FF) begin
      put_byte(c);
      col_in  = '0;
      col_out = '0;
    end else if (c == CH_SP) begin
      col_in = clamp_col(int'(col_in) + 1);
    end else if (c == CH_HT) begin
      col_in = clamp_col((int'(col_in) & ~7) + 8);
    end else begin
      // Close the gap: tabs to every stop not past the target, then spaces.
      tgt = int'(clamp_col(int'(col_in) + int'(shadow_indent)));
      while (((int'(col_out) + 8) & ~7) <= tgt) begin
        put_byte(CH_HT);
        col_out = 8'((int'(col_out) + 8) & ~7);
      end
      while (int'(col_out) < tgt) begin
        put_byte(CH_SP);
        col_out = col_out + 8'd1;
      end
      if (c == CH_BS || c == CH_RS) begin
        // Step back, or drop the backspace at column 0.
        if (col_in != 0) begin
          col_in = col_in - 8'd1;
          if (col_out != 0) col_out = col_out - 8'd1;
          put_byte(c);
        end
      end else if ((c != 8'h00 && c < CH_SP) || (c > CH_META && c < CH_METASP)) begin
        put_byte(c);
      end else begin
        col_in  = clamp_col(int'(col_in) + 1);
        col_out = clamp_col(int'(col_out) + 1);
        put_byte(c);
      end
    end
    if (predicted_bytes.size() > 0) predicted_bytes[$].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table helpers
  // ---------------------------------------------------------------------------

  function automatic stim_row_t row_word(input logic [7:0] c, input logic nf);
    stim_row_t r;
    r = '0;
    r.kind = ROW_WORD;
    r.ch   = c;
    r.nf   = nf;
    return r;
  endfunction

  function automatic stim_row_t row_typed(input logic [7:0] c, input logic nf,
                                          input logic [7:0] want, input int cnt);
    stim_row_t r;
    r = row_word(c, nf);
    r.typed   = 1'b1;
    r.exp_ch  = want;
    r.exp_cnt = 5'(cnt);
    return r;
  endfunction

  function automatic stim_row_t row_cfg(input logic sel, input int val);
    stim_row_t r;
    r = '0;
    r.kind    = ROW_CFG;
    r.reg_sel = sel;
    r.reg_val = INDENT_W'(val);
    return r;
  endfunction

  // Random text: mostly printable runs with blanks and line ends, now and then
  // a long run of tabs to drive the columns into saturation.
  function automatic logic [7:0] pick_text_byte();
    int r;
    if (tab_run > 0) begin
      tab_run--;
      return CH_HT;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      tab_run = $urandom_range(20, 34);
      return CH_HT;
    end
    if (r < 35) return 8'($urandom_range(8'h21, 8'h7E));
    if (r < 50) return CH_SP;
    if (r < 58) return CH_HT;
    if (r < 64) return CH_NL;
    if (r < 68) return ($urandom_range(0, 1) == 0) ? CH_CR : CH_FF;
    if (r < 74) return ($urandom_range(0, 1) == 0) ? CH_BS : CH_RS;
    if (r < 80) return 8'($urandom_range(8'h01, 8'h1F));
    if (r < 88) return 8'($urandom_range(8'h80, 8'hFF));
    return 8'($urandom_range(0, 255));
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side: all tasks start and end at a falling edge
  // ---------------------------------------------------------------------------

  // Offer one word. Predict it as soon as it is offered: the payload holds
  // until acceptance and results only appear after acceptance.
  task automatic send_word(input logic [7:0] c, input logic nf, input logic typed,
                           input logic [7:0] want, input int cnt);
    int i;
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    respace_word(c, nf);
    if (typed) begin
      for (i = 0; i < cnt; i++)
        expected_bytes.push_back('{ch: want, last: (i == cnt - 1)});
    end else begin
      foreach (predicted_bytes[i]) expected_bytes.push_back(predicted_bytes[i]);
    end
    in_valid     = 1'b1;
    in_data_byte = c;
    in_new_file  = nf;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Stop offering and wait until every expected word is out, then let any
  // word that causes nothing finish inside the block.
  task automatic drain_block();
    in_valid = 1'b0;
    while (expected_bytes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register write on an idle block: setup cycle, then access cycle.
  task automatic write_reg(input logic sel, input logic [INDENT_W-1:0] val);
    drain_block();
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {sel, 2'b00};
    pwdata  = 32'(val);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    if (sel == REG_LREP) shadow_lrep = val[LREP_W-1:0];
    else shadow_indent = val;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side
  // ---------------------------------------------------------------------------

  // Drive out_ready: a requested hold-off wins, else stall at the phase's rate.
  always @(negedge clk) begin
    if (holds_seen != hold_requests) begin
      holds_seen = hold_requests;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else begin
      out_ready = ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  function automatic void report_mismatch(input string what, input int want, input int got);
    error_count++;
    if (error_count <= 10)
      $display("%0t: mismatch on %s: expected 0x%02h, got 0x%02h", $realtime, what, want, got);
  endfunction

  // Compare each accepted output word with the oldest expectation.
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch("unexpected output word", 0, int'(out_byte));
      end else begin
        want = expected_bytes.pop_front();
        if (out_byte !== want.ch) report_mismatch("out_byte", int'(want.ch), int'(out_byte));
        if (out_last !== want.last)
          report_mismatch("out_last", int'(want.last), int'(out_last));
      end
    end
  end

  // Watchdog: end the run if no handshake of any kind happens for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
      quiet_cycles <= 0;
    else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin
    stim_row_t  row;
    logic [7:0] c;
    int         k, ph, sub, set_idx;
    int         lrep_v, indent_v;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part, with reset values of the registers at first.
    directed_rows.push_back(row_typed(CH_NL, 1'b0, CH_NL, 2));
    directed_rows.push_back(row_typed("A", 1'b0, "A", 1));
    directed_rows.push_back(row_typed(CH_SP, 1'b0, CH_SP, 0));
    directed_rows.push_back(row_typed(CH_HT, 1'b0, CH_HT, 0));
    directed_rows.push_back(row_word("B", 1'b0));
    directed_rows.push_back(row_word(CH_BS, 1'b0));
    directed_rows.push_back(row_word(CH_RS, 1'b0));
    directed_rows.push_back(row_word(8'h00, 1'b0));
    directed_rows.push_back(row_word(CH_META, 1'b0));
    directed_rows.push_back(row_word(CH_METASP, 1'b0));
    directed_rows.push_back(row_word(8'hFF, 1'b0));
    directed_rows.push_back(row_word(8'h81, 1'b0));
    directed_rows.push_back(row_word(8'h9F, 1'b0));
    directed_rows.push_back(row_word(8'h01, 1'b0));
    directed_rows.push_back(row_word(8'h1F, 1'b0));
    directed_rows.push_back(row_word(8'h7F, 1'b0));
    directed_rows.push_back(row_typed(CH_CR, 1'b0, CH_CR, 1));
    // Backspace at column 0 is dropped.
    directed_rows.push_back(row_typed(CH_BS, 1'b0, CH_BS, 0));
    directed_rows.push_back(row_typed(CH_FF, 1'b1, CH_FF, 1));
    // Zero repeat: a newline emits nothing but still clears the columns.
    directed_rows.push_back(row_cfg(REG_LREP, 0));
    directed_rows.push_back(row_typed(CH_NL, 1'b0, CH_NL, 0));
    // Largest repeat and indent: long gap, fifteen newlines.
    directed_rows.push_back(row_cfg(REG_LREP, 15));
    directed_rows.push_back(row_cfg(REG_INDENT, 127));
    directed_rows.push_back(row_word("x", 1'b0));
    directed_rows.push_back(row_typed(CH_NL, 1'b0, CH_NL, 15));
    directed_rows.push_back(row_word("y", 1'b1));
    directed_rows.push_back(row_word(CH_RS, 1'b0));

    tx_idle_pct = 38;
    rx_idle_pct = 71;
    for (k = 0; k < directed_rows.size(); k++) begin
      row = directed_rows[k];
      if (row.kind == ROW_CFG) write_reg(row.reg_sel, row.reg_val);
      else send_word(row.ch, row.nf, row.typed, row.exp_ch, int'(row.exp_cnt));
    end

    // Random part: three idling phases, two register settings each.
    for (ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 38 : (ph == 1) ? 71 : 0;
      rx_idle_pct = (ph == 0) ? 71 : (ph == 1) ? 38 : 0;
      for (sub = 0; sub < 2; sub++) begin
        set_idx = ph * 2 + sub;
        case (set_idx)
          0: begin lrep_v = 1;  indent_v = 3;   end
          1: begin lrep_v = 8;  indent_v = 127; end
          2: begin lrep_v = 0;  indent_v = 5;   end
          3: begin lrep_v = 15; indent_v = 0;   end
          4: begin
            lrep_v   = $urandom_range(0, 15);
            indent_v = $urandom_range(0, 127);
          end
          default: begin lrep_v = 2; indent_v = 64; end
        endcase
        write_reg(REG_LREP, INDENT_W'(lrep_v));
        write_reg(REG_INDENT, INDENT_W'(indent_v));
        tab_run = 0;
        for (k = 0; k < WORDS_PER_SET; k++) begin
          // Hold the receiver off for a long stretch while words keep coming.
          if (set_idx == 4 && k == 5) hold_requests++;
          c = pick_text_byte();
          send_word(c, ($urandom_range(0, 49) == 0), 1'b0, 8'h00, 0);
        end
      end
    end

    drain_block();
    repeat (10) @(posedge clk);
    if (error_count == 0 && expected_bytes.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
